// File: hw/rtl/mfq_pkg.sv
package mfq_pkg;

  localparam int DEPTH    = 32;
  localparam int LEVELS   = 3;
  localparam int RAM_DEPTH = LEVELS * DEPTH;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LIVE_W   = CNT_W + 2;
  localparam int ADDR_W   = $clog2(LEVELS * DEPTH);
  localparam int ID_W     = 8;
  localparam int TIME_W   = 16;
  localparam int ENTRY_W  = ID_W + TIME_W;
  localparam int TOTAL_W  = 32;
  localparam int LVL_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] LVL_ONE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_TWO   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_THREE = 2'd2;

  localparam logic [1:0] STAT_ADMIT = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_SLICE = 2'd2;
  localparam logic [1:0] STAT_IDLE  = 2'd3;

  localparam logic CMD_ADMIT    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_L1_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_QUANTUM = 2'd1;

  localparam logic [TIME_W-1:0] L1_QUANTUM_RST = 16'd4;
  localparam logic [TIME_W-1:0] L2_QUANTUM_RST = 16'd8;

  typedef enum logic {
    ST_ACCEPT,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] slice;
    logic [TIME_W-1:0] remain;
    logic              done;
    logic              demote;
  } slice_res_t;

  function automatic logic [PTR_W-1:0] ring_tail(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W:0] sum;
    sum = (PTR_W + 1)'(ptr) + (PTR_W + 1)'(1);
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = '0;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

// File: hw/rtl/multilevel_feedback_queue_scheduler.sv
// Three-level feedback-queue scheduler; jobs live in one shared ring RAM.
// Admit, reject and idle transactions give a result in the cycle after
// acceptance; a dispatch goes through the RAM read register, then the update.
// Throughput: 1 admit per cycle unless the output stalls; no new item is
// taken while a dispatch updates (registered RAM read). No clearing pass.
// Reset (rst_n low, synchronous): rings empty, elapsed time 0, quanta 4 and 8.
module multilevel_feedback_queue_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [mfq_pkg::ID_W-1:0]      in_job_id,
  input  logic [mfq_pkg::TIME_W-1:0]    in_burst_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [mfq_pkg::ID_W-1:0]      out_served_id,
  output logic [mfq_pkg::TIME_W-1:0]    out_slice_run,
  output logic [mfq_pkg::LVL_W-1:0]     out_served_level,
  output logic                          out_job_done,
  output logic [mfq_pkg::TOTAL_W-1:0]   out_elapsed_time,
  input  logic                          cfg_wr_en,
  input  logic [mfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfq_pkg::TIME_W-1:0]    cfg_wr_data
);

  mfq_pkg::state_t                state_r, state_nxt;
  logic [mfq_pkg::PTR_W-1:0]      head_r [mfq_pkg::LEVELS];
  logic [mfq_pkg::PTR_W-1:0]      head_nxt [mfq_pkg::LEVELS];
  logic [mfq_pkg::CNT_W-1:0]      cnt_r [mfq_pkg::LEVELS];
  logic [mfq_pkg::CNT_W-1:0]      cnt_nxt [mfq_pkg::LEVELS];
  logic [mfq_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [mfq_pkg::LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [mfq_pkg::TIME_W-1:0]     l1_quantum_r, l2_quantum_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic [mfq_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic [mfq_pkg::TIME_W-1:0]     out_slice_r, out_slice_nxt;
  logic [mfq_pkg::LVL_W-1:0]      out_level_r, out_level_nxt;
  logic                           out_done_r, out_done_nxt;
  logic [mfq_pkg::TOTAL_W-1:0]    out_elapsed_r, out_elapsed_nxt;
  logic                           out_load;

  logic                           ready;
  logic                           accept;
  logic [mfq_pkg::LIVE_W-1:0]     live;
  logic                           full;
  logic                           any_job;
  logic [mfq_pkg::LVL_W-1:0]      sel_lvl;
  logic [mfq_pkg::LVL_W-1:0]      next_lvl;

  logic                           wr_en;
  logic [mfq_pkg::ADDR_W-1:0]     wr_addr;
  logic [mfq_pkg::ENTRY_W-1:0]    wr_data;
  logic                           rd_en;
  logic [mfq_pkg::ADDR_W-1:0]     rd_addr;
  logic [mfq_pkg::ENTRY_W-1:0]    rd_data;
  mfq_pkg::slice_res_t            res;

  mfq_ram #(
    .WIDTH (mfq_pkg::ENTRY_W),
    .DEPTH (mfq_pkg::RAM_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mfq_slice u_slice (
    .entry      (rd_data),
    .lvl        (lvl_r),
    .l1_quantum (l1_quantum_r),
    .l2_quantum (l2_quantum_r),
    .res        (res)
  );

  assign ready    = (state_r == mfq_pkg::ST_ACCEPT) && (!out_valid_r || !out_stall);
  assign accept   = in_valid && ready;
  assign in_stall = !ready;
  assign live     = mfq_pkg::LIVE_W'(cnt_r[0]) + mfq_pkg::LIVE_W'(cnt_r[1])
                  + mfq_pkg::LIVE_W'(cnt_r[2]);
  assign full     = live >= mfq_pkg::LIVE_W'(mfq_pkg::DEPTH);
  assign any_job  = (cnt_r[0] != '0) || (cnt_r[1] != '0) || (cnt_r[2] != '0);
  assign next_lvl = lvl_r + mfq_pkg::LVL_W'(1);

  always_comb begin
    if (cnt_r[0] != '0) begin
      sel_lvl = mfq_pkg::LVL_ONE;
    end else if (cnt_r[1] != '0) begin
      sel_lvl = mfq_pkg::LVL_TWO;
    end else begin
      sel_lvl = mfq_pkg::LVL_THREE;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    total_nxt       = total_r;
    lvl_nxt         = lvl_r;
    out_load        = 1'b0;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_slice_nxt   = out_slice_r;
    out_level_nxt   = out_level_r;
    out_done_nxt    = out_done_r;
    out_elapsed_nxt = out_elapsed_r;
    wr_en           = 1'b0;
    wr_addr         = mfq_pkg::ring_addr(mfq_pkg::LVL_ONE,
                        mfq_pkg::ring_tail(head_r[0], cnt_r[0]));
    wr_data         = {in_job_id, in_burst_length};
    rd_en           = 1'b0;
    rd_addr         = mfq_pkg::ring_addr(sel_lvl, head_r[sel_lvl]);

    unique case (state_r)
      mfq_pkg::ST_ACCEPT: begin
        if (accept) begin
          out_slice_nxt   = '0;
          out_level_nxt   = '0;
          out_done_nxt    = 1'b0;
          out_id_nxt      = '0;
          out_elapsed_nxt = total_r;
          if (in_command == mfq_pkg::CMD_ADMIT) begin
            out_load = 1'b1;
            if (full) begin
              out_status_nxt = mfq_pkg::STAT_FULL;
            end else begin
              out_status_nxt = mfq_pkg::STAT_ADMIT;
              out_id_nxt     = in_job_id;
              wr_en          = 1'b1;
              cnt_nxt[0]     = cnt_r[0] + mfq_pkg::CNT_W'(1);
            end
          end else if (!any_job) begin
            out_load       = 1'b1;
            out_status_nxt = mfq_pkg::STAT_IDLE;
          end else begin
            rd_en     = 1'b1;
            lvl_nxt   = sel_lvl;
            state_nxt = mfq_pkg::ST_EXEC;
          end
        end
      end
      mfq_pkg::ST_EXEC: begin
        head_nxt[lvl_r] = mfq_pkg::ring_next(head_r[lvl_r]);
        cnt_nxt[lvl_r]  = cnt_r[lvl_r] - mfq_pkg::CNT_W'(1);
        total_nxt       = total_r + mfq_pkg::TOTAL_W'(res.slice);
        if (res.demote) begin
          wr_en             = 1'b1;
          wr_addr           = mfq_pkg::ring_addr(next_lvl,
                                mfq_pkg::ring_tail(head_r[next_lvl], cnt_r[next_lvl]));
          wr_data           = {rd_data[mfq_pkg::ENTRY_W-1:mfq_pkg::TIME_W], res.remain};
          cnt_nxt[next_lvl] = cnt_r[next_lvl] + mfq_pkg::CNT_W'(1);
        end
        out_load        = 1'b1;
        out_status_nxt  = mfq_pkg::STAT_SLICE;
        out_id_nxt      = rd_data[mfq_pkg::ENTRY_W-1:mfq_pkg::TIME_W];
        out_slice_nxt   = res.slice;
        out_level_nxt   = next_lvl;
        out_done_nxt    = res.done;
        out_elapsed_nxt = total_nxt;
        state_nxt       = mfq_pkg::ST_ACCEPT;
      end
      default: state_nxt = mfq_pkg::ST_ACCEPT;
    endcase

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfq_pkg::ST_ACCEPT;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      l1_quantum_r <= mfq_pkg::L1_QUANTUM_RST;
      l2_quantum_r <= mfq_pkg::L2_QUANTUM_RST;
      for (int i = 0; i < mfq_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          mfq_pkg::REG_L1_QUANTUM: l1_quantum_r <= cfg_wr_data;
          mfq_pkg::REG_L2_QUANTUM: l2_quantum_r <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r         <= lvl_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_slice_r   <= out_slice_nxt;
    out_level_r   <= out_level_nxt;
    out_done_r    <= out_done_nxt;
    out_elapsed_r <= out_elapsed_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_served_id    = out_id_r;
  assign out_slice_run    = out_slice_r;
  assign out_served_level = out_level_r;
  assign out_job_done     = out_done_r;
  assign out_elapsed_time = out_elapsed_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live <= mfq_pkg::LIVE_W'(mfq_pkg::DEPTH))
    else $error("live job count exceeds ring depth");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfq_pkg::ST_EXEC) |-> !out_valid_r)
    else $error("dispatch update with output slot occupied");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfq_pkg::ST_EXEC) |=> (out_valid_r && out_status_r == mfq_pkg::STAT_SLICE))
    else $error("dispatch update gave no slice result");

  a_exec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfq_pkg::ST_EXEC) |-> (cnt_r[lvl_r] != '0))
    else $error("pop from an empty ring");

endmodule

// File: hw/rtl/mfq_ram.sv
module mfq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/mfq_slice.sv
module mfq_slice (
  input  logic [mfq_pkg::ENTRY_W-1:0] entry,
  input  logic [mfq_pkg::LVL_W-1:0]   lvl,
  input  logic [mfq_pkg::TIME_W-1:0]  l1_quantum,
  input  logic [mfq_pkg::TIME_W-1:0]  l2_quantum,
  output mfq_pkg::slice_res_t         res
);

  logic [mfq_pkg::TIME_W-1:0] rem;
  logic [mfq_pkg::TIME_W-1:0] quantum;
  logic [mfq_pkg::TIME_W-1:0] slice;
  logic                       last_level;

  always_comb begin
    rem        = entry[mfq_pkg::TIME_W-1:0];
    last_level = (lvl == mfq_pkg::LVL_THREE);
    quantum    = (lvl == mfq_pkg::LVL_ONE) ? l1_quantum : l2_quantum;
    if (last_level) begin
      slice = rem;
    end else begin
      slice = (rem < quantum) ? rem : quantum;
    end
    res.slice  = slice;
    res.remain = rem - slice;
    res.done   = last_level || (res.remain == '0);
    res.demote = !res.done;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int LONG_HOLD      = 250;
  localparam int PHASE_ITEMS    = 210;

  localparam logic [mfq_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [mfq_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0]                  status;
    logic [mfq_pkg::ID_W-1:0]    served_id;
    logic [mfq_pkg::TIME_W-1:0]  slice_run;
    logic [mfq_pkg::LVL_W-1:0]   served_level;
    logic                        job_done;
    logic [mfq_pkg::TOTAL_W-1:0] elapsed_time;
  } outcome_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_command = mfq_pkg::CMD_ADMIT;
  logic [mfq_pkg::ID_W-1:0]      in_job_id = '0;
  logic [mfq_pkg::TIME_W-1:0]    in_burst_length = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_status;
  logic [mfq_pkg::ID_W-1:0]      out_served_id;
  logic [mfq_pkg::TIME_W-1:0]    out_slice_run;
  logic [mfq_pkg::LVL_W-1:0]     out_served_level;
  logic                          out_job_done;
  logic [mfq_pkg::TOTAL_W-1:0]   out_elapsed_time;
  logic                          cfg_wr_en = 1'b0;
  logic [mfq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mfq_pkg::TIME_W-1:0]    cfg_wr_data = '0;

  logic [mfq_pkg::ENTRY_W-1:0] job_ring [mfq_pkg::LEVELS][mfq_pkg::DEPTH];
  int unsigned                 ring_head [mfq_pkg::LEVELS] = '{default: 0};
  int unsigned                 ring_count [mfq_pkg::LEVELS] = '{default: 0};
  logic [mfq_pkg::TOTAL_W-1:0] service_clock = '0;
  logic [mfq_pkg::TIME_W-1:0]  quantum_one = mfq_pkg::L1_QUANTUM_RST;
  logic [mfq_pkg::TIME_W-1:0]  quantum_two = mfq_pkg::L2_QUANTUM_RST;

  outcome_t pending_outcomes [$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  bit       idle_on = 1'b1;
  int       hold_request = 0;
  int       hold_left = 0;
  int       stall_left = 0;

  multilevel_feedback_queue_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_job_id        (in_job_id),
    .in_burst_length  (in_burst_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_served_id    (out_served_id),
    .out_slice_run    (out_slice_run),
    .out_served_level (out_served_level),
    .out_job_done     (out_job_done),
    .out_elapsed_time (out_elapsed_time),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned live_jobs();
    return ring_count[mfq_pkg::LVL_ONE] + ring_count[mfq_pkg::LVL_TWO]
         + ring_count[mfq_pkg::LVL_THREE];
  endfunction

  function automatic void push_job(logic [mfq_pkg::LVL_W-1:0] lvl,
                                   logic [mfq_pkg::ENTRY_W-1:0] job);
    int unsigned slot;
    slot = (ring_head[lvl] + ring_count[lvl]) % mfq_pkg::DEPTH;
    job_ring[lvl][slot] = job;
    ring_count[lvl]++;
  endfunction

  function automatic outcome_t predict_outcome(logic cmd, logic [mfq_pkg::ID_W-1:0] id,
                                               logic [mfq_pkg::TIME_W-1:0] burst);
    outcome_t                    res;
    logic [mfq_pkg::LVL_W-1:0]   lvl;
    logic [mfq_pkg::ENTRY_W-1:0] job;
    logic [mfq_pkg::TIME_W-1:0]  remain;
    logic [mfq_pkg::TIME_W-1:0]  quantum;
    bit                          found;
    res = '0;
    found = 1'b1;
    if (cmd == mfq_pkg::CMD_ADMIT) begin
      if (live_jobs() >= mfq_pkg::DEPTH) begin
        res.status = mfq_pkg::STAT_FULL;
      end else begin
        push_job(mfq_pkg::LVL_ONE, {id, burst});
        res.status = mfq_pkg::STAT_ADMIT;
        res.served_id = id;
      end
    end else begin
      if (ring_count[mfq_pkg::LVL_ONE] != 0) lvl = mfq_pkg::LVL_ONE;
      else if (ring_count[mfq_pkg::LVL_TWO] != 0) lvl = mfq_pkg::LVL_TWO;
      else if (ring_count[mfq_pkg::LVL_THREE] != 0) lvl = mfq_pkg::LVL_THREE;
      else found = 1'b0;
      if (!found) begin
        res.status = mfq_pkg::STAT_IDLE;
      end else begin
        job = job_ring[lvl][ring_head[lvl]];
        ring_head[lvl] = (ring_head[lvl] + 1) % mfq_pkg::DEPTH;
        ring_count[lvl]--;
        remain = job[mfq_pkg::TIME_W-1:0];
        res.served_id = job[mfq_pkg::ENTRY_W-1:mfq_pkg::TIME_W];
        if (lvl == mfq_pkg::LVL_THREE) begin
          res.slice_run = remain;
        end else begin
          quantum = (lvl == mfq_pkg::LVL_ONE) ? quantum_one : quantum_two;
          res.slice_run = (remain < quantum) ? remain : quantum;
        end
        remain = remain - res.slice_run;
        service_clock = service_clock + mfq_pkg::TOTAL_W'(res.slice_run);
        if (remain != 0 && lvl != mfq_pkg::LVL_THREE) begin
          push_job(mfq_pkg::LVL_W'(lvl + 1), {res.served_id, remain});
        end else begin
          res.job_done = 1'b1;
        end
        res.served_level = mfq_pkg::LVL_W'(lvl + 1);
        res.status = mfq_pkg::STAT_SLICE;
      end
    end
    res.elapsed_time = service_clock;
    return res;
  endfunction

  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [mfq_pkg::TIME_W-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return mfq_pkg::TIME_W'($urandom_range(1, 24));
      6, 7: return mfq_pkg::TIME_W'($urandom_range(0, 255));
      default: return mfq_pkg::TIME_W'($urandom());
    endcase
  endfunction

  function automatic logic [mfq_pkg::TIME_W-1:0] pick_quantum();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return mfq_pkg::TIME_W'(1);
      1: return '1;
      default: return mfq_pkg::TIME_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic send_item(logic cmd, logic [mfq_pkg::ID_W-1:0] id,
                           logic [mfq_pkg::TIME_W-1:0] burst);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_job_id <= id;
    in_burst_length <= burst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(cmd, id, burst));
    gap = idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_dispatch();
    send_item(mfq_pkg::CMD_DISPATCH, mfq_pkg::ID_W'($urandom_range(0, 255)), pick_burst());
  endtask

  task automatic drain_jobs();
    while (live_jobs() != 0) send_dispatch();
    send_dispatch();
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [mfq_pkg::CFG_IDX_W-1:0] idx,
                                logic [mfq_pkg::TIME_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    case (idx)
      mfq_pkg::REG_L1_QUANTUM: quantum_one = value;
      mfq_pkg::REG_L2_QUANTUM: quantum_two = value;
      default: ;
    endcase
  endtask

  task automatic set_quanta(logic [mfq_pkg::TIME_W-1:0] q1, logic [mfq_pkg::TIME_W-1:0] q2,
                            bit stray);
    settle_block();
    write_register(mfq_pkg::REG_L1_QUANTUM, q1);
    if (stray) write_register(REG_SPARE_A, '1);
    write_register(mfq_pkg::REG_L2_QUANTUM, q2);
    if (stray) write_register(REG_SPARE_B, mfq_pkg::TIME_W'($urandom()));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_traffic(int count, int admit_pct);
    logic cmd;
    repeat (count) begin
      cmd = ($urandom_range(0, 99) < admit_pct) ? mfq_pkg::CMD_ADMIT : mfq_pkg::CMD_DISPATCH;
      send_item(cmd, mfq_pkg::ID_W'($urandom_range(0, 255)), pick_burst());
    end
  endtask

  task automatic test_directed_slices();
    send_dispatch();
    send_item(mfq_pkg::CMD_ADMIT, 8'h00, 16'h0000);
    send_item(mfq_pkg::CMD_ADMIT, 8'hFF, 16'hFFFF);
    send_item(mfq_pkg::CMD_ADMIT, 8'hA5, 16'd4);
    send_item(mfq_pkg::CMD_ADMIT, 8'h5A, 16'd9);
    send_item(mfq_pkg::CMD_ADMIT, 8'h3C, 16'd1);
    drain_jobs();
    send_item(mfq_pkg::CMD_ADMIT, 8'h11, 16'd30);
    send_dispatch();
    send_item(mfq_pkg::CMD_ADMIT, 8'h22, 16'd2);
    send_dispatch();
    drain_jobs();
  endtask

  task automatic test_quantum_settings();
    set_quanta('0, '0, 1'b1);
    send_item(mfq_pkg::CMD_ADMIT, 8'h81, 16'd7);
    send_item(mfq_pkg::CMD_ADMIT, 8'h00, 16'd0);
    send_item(mfq_pkg::CMD_ADMIT, 8'h7E, 16'hFFFF);
    drain_jobs();
    set_quanta('1, 16'd1, 1'b0);
    send_item(mfq_pkg::CMD_ADMIT, 8'hFF, 16'hFFFF);
    send_item(mfq_pkg::CMD_ADMIT, 8'h01, 16'd300);
    drain_jobs();
    set_quanta(16'd1, '1, 1'b1);
    send_item(mfq_pkg::CMD_ADMIT, 8'h42, 16'hFFFF);
    send_item(mfq_pkg::CMD_ADMIT, 8'h24, 16'd2);
    drain_jobs();
    set_quanta(mfq_pkg::L1_QUANTUM_RST, mfq_pkg::L2_QUANTUM_RST, 1'b0);
  endtask

  task automatic test_full_backpressure();
    idle_on = 1'b0;
    hold_request = LONG_HOLD;
    repeat (mfq_pkg::DEPTH + 4) begin
      send_item(mfq_pkg::CMD_ADMIT, mfq_pkg::ID_W'($urandom_range(0, 255)), pick_burst());
    end
    settle_block();
    idle_on = 1'b1;
    drain_jobs();
  endtask

  task automatic test_random_mix();
    int admit_pct [8] = '{55, 70, 35, 50, 80, 45, 60, 40};
    for (int phase = 0; phase < 8; phase++) begin
      set_quanta(pick_quantum(), pick_quantum(), phase[0]);
      idle_on = (phase != 3);
      random_traffic(PHASE_ITEMS, admit_pct[phase]);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (idle_on) stall_left = idle_gap();
    end
  end

  task automatic flag_mismatch(string field, logic [mfq_pkg::TOTAL_W-1:0] want,
                               logic [mfq_pkg::TOTAL_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual status %0h id %0h",
                 $time, out_status, out_served_id);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", mfq_pkg::TOTAL_W'(want.status),
                        mfq_pkg::TOTAL_W'(out_status));
        if (out_served_id !== want.served_id)
          flag_mismatch("served_id", mfq_pkg::TOTAL_W'(want.served_id),
                        mfq_pkg::TOTAL_W'(out_served_id));
        if (out_slice_run !== want.slice_run)
          flag_mismatch("slice_run", mfq_pkg::TOTAL_W'(want.slice_run),
                        mfq_pkg::TOTAL_W'(out_slice_run));
        if (out_served_level !== want.served_level)
          flag_mismatch("served_level", mfq_pkg::TOTAL_W'(want.served_level),
                        mfq_pkg::TOTAL_W'(out_served_level));
        if (out_job_done !== want.job_done)
          flag_mismatch("job_done", mfq_pkg::TOTAL_W'(want.job_done),
                        mfq_pkg::TOTAL_W'(out_job_done));
        if (out_elapsed_time !== want.elapsed_time)
          flag_mismatch("elapsed_time", want.elapsed_time, out_elapsed_time);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_slices();
    test_quantum_settings();
    test_full_backpressure();
    test_random_mix();
    settle_block();
    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
